FILE: rtl/dsp_pkg.sv
// Shared types and constants for the dot-star pattern matcher.
package dsp_pkg;

	localparam int PATTERN_MAX_DEF = 16;
	localparam int PAT_BYTES       = 16;
	localparam int REG_W           = 64;
	localparam int LEN_W           = 5;
	localparam int IDX_W           = 2;

	localparam logic [7:0] STAR_BYTE = 8'h2A;
	localparam logic [7:0] DOT_BYTE  = 8'h2E;

	localparam logic [IDX_W-1:0] REG_CHARS_LOW  = 2'd0;
	localparam logic [IDX_W-1:0] REG_CHARS_HIGH = 2'd1;
	localparam logic [IDX_W-1:0] REG_LENGTH     = 2'd2;

	typedef struct packed {
		logic [7:0] text_char;
		logic       char_present;
		logic       last_char;
	} in_item_t;

	typedef struct packed {
		logic matched;
		logic text_done;
	} out_item_t;

	// Per-cycle control broadcast to every cell.
	typedef struct packed {
		logic             accept;
		logic             awaiting;
		logic             present;
		logic [7:0]       text_char;
		logic [LEN_W-1:0] used_len;
	} ctrl_t;

	// What one cell hands to its right-hand neighbors.
	typedef struct packed {
		logic start;
		logic base;
		logic nxt;
	} link_t;

endpackage

FILE: rtl/dsp_if.sv
// Valid/ready stream interfaces for the input and result channels.
interface dsp_in_if;
	logic             valid;
	logic             ready;
	dsp_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dsp_out_if;
	logic              valid;
	logic              ready;
	dsp_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/dot_star_pattern_matcher.sv
// Top level of the dot-star pattern matcher: config registers, cell row, result register.
//
//  channel     | dir | handshake       | payload
//  ------------+-----+-----------------+-----------------------------------------
//  in_stream   | in  | valid / ready   | text_char[7:0], char_present, last_char
//  out_stream  | out | valid / ready   | matched, text_done
//  cfg         | in  | cfg_we          | cfg_index[1:0], cfg_data[63:0]
//
// One item per cycle unless out_stream stalls: each byte updates the whole row of position cells in the cycle
// it transfers; the star-skip ripple along the cell row sets the clock period, not the rate.
// The result appears in the cycle after its item transfers and sits in an output register.
// in_stream.ready is high whenever that register is empty or being drained.
// Reset clears the pattern, the length and all positions, and arms a new text.
module dot_star_pattern_matcher #(
	parameter int PATTERN_MAX = dsp_pkg::PATTERN_MAX_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	dsp_in_if.sink                            in_stream,
	dsp_out_if.source                         out_stream,
	input  logic                              cfg_we,
	input  logic [dsp_pkg::IDX_W-1:0]         cfg_index,
	input  logic [dsp_pkg::REG_W-1:0]         cfg_data
);

	localparam int NCELL = PATTERN_MAX + 1;
	localparam logic [dsp_pkg::LEN_W-1:0] MAX_L = dsp_pkg::LEN_W'(PATTERN_MAX);

	logic [dsp_pkg::REG_W-1:0]        low_q;
	logic [dsp_pkg::REG_W-1:0]        high_q;
	logic [dsp_pkg::LEN_W-1:0]        len_q;
	logic                             awaiting_q;
	logic                             out_valid_q;
	dsp_pkg::out_item_t               out_q;

	logic [dsp_pkg::PAT_BYTES-1:0][7:0] pat_bytes;
	logic [dsp_pkg::LEN_W-1:0]        used_len;
	logic                             accept;
	dsp_pkg::ctrl_t                   ctrl;
	dsp_pkg::link_t                   links [NCELL];
	logic [NCELL-1:0]                 new_vec;
	logic [NCELL-1:0]                 end_vec;
	logic                             matched;

	// Configuration writes; an index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '0;
			high_q <= '0;
			len_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				dsp_pkg::REG_CHARS_LOW:  low_q  <= cfg_data;
				dsp_pkg::REG_CHARS_HIGH: high_q <= cfg_data;
				dsp_pkg::REG_LENGTH:     len_q  <= cfg_data[dsp_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign pat_bytes = {high_q, low_q};

	// Clamp an oversized length to the row size.
	assign used_len = (len_q > MAX_L) ? MAX_L : len_q;

	// Take a new item whenever the result register is free or draining.
	assign in_stream.ready = !out_valid_q || out_stream.ready;
	assign accept          = in_stream.valid && in_stream.ready;

	assign ctrl.accept    = accept;
	assign ctrl.awaiting  = awaiting_q;
	assign ctrl.present   = in_stream.data.char_present;
	assign ctrl.text_char = in_stream.data.text_char;
	assign ctrl.used_len  = used_len;

	// Row of position cells; cell g sees pattern bytes g-1 and g-2 and its two left neighbors.
	for (genvar g = 0; g < NCELL; g++) begin : g_cell
		logic [7:0]     prev1;
		logic [7:0]     prev2;
		dsp_pkg::link_t from1;
		dsp_pkg::link_t from2;

		if (g >= 1) begin : g_l1
			assign prev1 = pat_bytes[g-1];
			assign from1 = links[g-1];
		end else begin : g_n1
			assign prev1 = '0;
			assign from1 = '0;
		end

		if (g >= 2) begin : g_l2
			assign prev2 = pat_bytes[g-2];
			assign from2 = links[g-2];
		end else begin : g_n2
			assign prev2 = '0;
			assign from2 = '0;
		end

		dsp_cell #(
			.IDX (g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.pat_prev1 (prev1),
			.pat_prev2 (prev2),
			.from1     (from1),
			.from2     (from2),
			.link      (links[g]),
			.new_bit   (new_vec[g]),
			.at_end    (end_vec[g])
		);
	end

	// Whole-pattern match: the position at the used length is live.
	assign matched = |(new_vec & end_vec);

	// Hold the text boundary; the item after a last byte starts a fresh text.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b1;
		end else if (accept) begin
			awaiting_q <= in_stream.data.last_char;
		end
	end

	// Result register: load on transfer in, drop on transfer out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_stream.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q.matched   <= matched;
			out_q.text_done <= in_stream.data.last_char;
		end
	end

	assign out_stream.valid = out_valid_q;
	assign out_stream.data  = out_q;

	// Every transferred item yields a result on the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("result missing after input transfer");

	// The verdict is tagged with the last_char of its own item.
	a_done_echo: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (out_q.text_done == $past(in_stream.data.last_char)))
		else $error("text_done does not follow last_char");

	// A text boundary arms the start vector for the next item.
	a_boundary: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (awaiting_q == $past(in_stream.data.last_char)))
		else $error("text boundary not tracked");

	// An empty pattern accepts an empty text.
	a_empty_match: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && awaiting_q && !in_stream.data.char_present && (used_len == '0))
		|=> out_q.matched)
		else $error("empty pattern failed to match empty text");

endmodule

FILE: rtl/dsp_cell.sv
// One NFA position cell: holds its active bit and computes its next value.
module dsp_cell #(
	parameter int IDX = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  dsp_pkg::ctrl_t  ctrl,
	input  logic [7:0]      pat_prev1,
	input  logic [7:0]      pat_prev2,
	input  dsp_pkg::link_t  from1,
	input  dsp_pkg::link_t  from2,
	output dsp_pkg::link_t  link,
	output logic            new_bit,
	output logic            at_end
);

	localparam logic [dsp_pkg::LEN_W-1:0] IDX_L = dsp_pkg::LEN_W'(IDX);
	localparam logic IS_ZERO  = (IDX == 0);
	localparam logic HAS1     = (IDX >= 1);
	localparam logic HAS2     = (IDX >= 2);
	localparam logic FIRST    = (IDX == 1);

	logic active_q;
	logic rng;
	logic star1;
	logic fits1;
	logic fits2;
	logic lit;
	logic loop_hit;

	assign rng    = (IDX_L <= ctrl.used_len);
	assign at_end = (IDX_L == ctrl.used_len);
	assign star1  = HAS1 && (pat_prev1 == dsp_pkg::STAR_BYTE);
	assign fits1  = (pat_prev1 == dsp_pkg::DOT_BYTE) || (pat_prev1 == ctrl.text_char);
	assign fits2  = (pat_prev2 == dsp_pkg::DOT_BYTE) || (pat_prev2 == ctrl.text_char);

	// Start vector: position 0 plus star skips.
	assign link.start = IS_ZERO || (HAS2 && rng && star1 && from2.start);
	assign link.base  = ctrl.awaiting ? link.start : (active_q && rng);

	// Advance on a literal or dot, loop on a starred byte, then skip past stars.
	assign lit      = HAS1 && rng && from1.base && (!star1 || FIRST) && fits1;
	assign loop_hit = HAS2 && star1 && link.base && fits2;
	assign link.nxt = lit || loop_hit || (HAS2 && rng && star1 && from2.nxt);

	assign new_bit = ctrl.present ? link.nxt : link.base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (ctrl.accept) begin
			active_q <= new_bit;
		end
	end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the dot-star pattern matcher: directed and random texts vs. a bit-vector predictor.
module testbench;

	localparam logic [7:0] CH_A = "a";
	localparam logic [7:0] CH_B = "b";

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         cfg_we;
	logic [dsp_pkg::IDX_W-1:0]    cfg_index;
	logic [dsp_pkg::REG_W-1:0]    cfg_data;

	dsp_in_if  in_ch ();
	dsp_out_if out_ch ();

	dot_star_pattern_matcher i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_stream  (in_ch),
		.out_stream (out_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #4 clk = ~clk;

	// Shadow copy of the pattern registers, updated at the edge that writes them.
	logic [dsp_pkg::REG_W-1:0] pat_lo  = '0;
	logic [dsp_pkg::REG_W-1:0] pat_hi  = '0;
	logic [dsp_pkg::LEN_W-1:0] pat_len = '0;

	// Shadow NFA state: live pattern positions and the start-of-text flag.
	logic [16:0] live_positions = '0;
	bit          text_start     = 1'b1;

	// Verdicts predicted at input transfer, waiting for their output transfer.
	dsp_pkg::out_item_t verdicts_due[$];
	dsp_pkg::out_item_t head_verdict;
	logic [7:0]         text_buf[$];

	int  items_sent   = 0;
	int  results_seen = 0;
	int  mismatches   = 0;
	int  stall_left   = 0;
	bit  src_gaps     = 1'b1;
	bit  snk_gaps     = 1'b1;

	// ---------------------------------------------------------------- predictor

	function automatic logic [7:0] pat_byte_at(input int idx);
		if (idx < 8)
			return pat_lo[8*idx +: 8];
		return pat_hi[8*(idx-8) +: 8];
	endfunction

	// Positions 0..len are meaningful; everything above is dropped.
	function automatic logic [16:0] span_mask(input int len);
		return 17'((32'd1 << (len + 1)) - 1);
	endfunction

	function automatic bit byte_fits(input logic [7:0] pc, input logic [7:0] c);
		return (pc == dsp_pkg::DOT_BYTE) || (pc == c);
	endfunction

	// Follow star skips left to right: from i to i+2 when byte i+1 is a star.
	function automatic logic [16:0] close_star_skips(input logic [16:0] v, input int len);
		for (int i = 0; i + 1 < len; i++) begin
			if (v[i] && pat_byte_at(i + 1) == dsp_pkg::STAR_BYTE)
				v[i+2] = 1'b1;
		end
		return v & span_mask(len);
	endfunction

	// Consume one text byte: literal/dot advances, starred bytes loop in place.
	function automatic logic [16:0] advance_positions(input logic [16:0] v, input int len,
			input logic [7:0] c);
		logic [16:0] nxt;
		nxt = '0;
		for (int i = 0; i <= len; i++) begin
			if (v[i]) begin
				// A star only counts as a literal at position 0.
				if (i < len && (pat_byte_at(i) != dsp_pkg::STAR_BYTE || i == 0) &&
						byte_fits(pat_byte_at(i), c))
					nxt[i+1] = 1'b1;
				if (i >= 2 && pat_byte_at(i - 1) == dsp_pkg::STAR_BYTE &&
						byte_fits(pat_byte_at(i - 2), c))
					nxt[i] = 1'b1;
			end
		end
		return close_star_skips(nxt, len);
	endfunction

	function automatic dsp_pkg::out_item_t predict_verdict(input dsp_pkg::in_item_t it);
		int                 len;
		logic [16:0]        v;
		dsp_pkg::out_item_t r;
		// Clamp oversized lengths to the full row.
		len = (pat_len > 16) ? 16 : int'(pat_len);
		if (text_start)
			v = close_star_skips(17'd1, len);
		else
			v = live_positions & span_mask(len);
		if (it.char_present)
			v = advance_positions(v, len, it.text_char);
		live_positions = v;
		text_start     = it.last_char;
		r.matched      = v[len];
		r.text_done    = it.last_char;
		return r;
	endfunction

	// ---------------------------------------------------------------- drivers

	// Offer one item, idling at random first; record its verdict on transfer.
	task automatic feed_item(input logic [7:0] c, input logic present, input logic last);
		dsp_pkg::in_item_t it;
		it.text_char    = c;
		it.char_present = present;
		it.last_char    = last;
		while (src_gaps && $urandom_range(99) < 37) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= it;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		verdicts_due.push_back(predict_verdict(it));
		items_sent++;
	endtask

	// Drop valid and hold until every predicted verdict has come back.
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (verdicts_due.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [dsp_pkg::IDX_W-1:0] idx,
			input logic [dsp_pkg::REG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			dsp_pkg::REG_CHARS_LOW:  pat_lo  = val;
			dsp_pkg::REG_CHARS_HIGH: pat_hi  = val;
			dsp_pkg::REG_LENGTH:     pat_len = val[dsp_pkg::LEN_W-1:0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Drain, then load a pattern given as a string plus a length value.
	task automatic set_pattern(input string s, input logic [dsp_pkg::LEN_W-1:0] len);
		logic [127:0] bytes;
		bytes = '0;
		for (int i = 0; i < s.len() && i < 16; i++)
			bytes[8*i +: 8] = s[i];
		wait_drained();
		write_reg(dsp_pkg::REG_CHARS_LOW, bytes[63:0]);
		write_reg(dsp_pkg::REG_CHARS_HIGH, bytes[127:64]);
		write_reg(dsp_pkg::REG_LENGTH, dsp_pkg::REG_W'(len));
	endtask

	// Send text_buf as one text; sprinkle empty items, sometimes close with one.
	task automatic send_text(input bit close_text);
		int n;
		bit end_blank;
		n = text_buf.size();
		end_blank = close_text && (n == 0 || $urandom_range(9) == 0);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(99) < 8)
				feed_item(8'($urandom), 1'b0, 1'b0);
			feed_item(text_buf[k], 1'b1, close_text && !end_blank && k == n - 1);
		end
		if (end_blank)
			feed_item(8'($urandom), 1'b0, 1'b1);
	endtask

	function automatic logic [7:0] pick_text_byte();
		case ($urandom_range(9))
			0, 1, 2: return CH_A;
			3, 4:    return CH_B;
			5:       return dsp_pkg::STAR_BYTE;
			6:       return dsp_pkg::DOT_BYTE;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [7:0] pick_pattern_byte();
		case ($urandom_range(8))
			0, 1, 2: return CH_A;
			3:       return CH_B;
			4, 5:    return dsp_pkg::STAR_BYTE;
			6, 7:    return dsp_pkg::DOT_BYTE;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Expand the current pattern into a text it accepts, optionally mutated once.
	task automatic sketch_matching_text(input bit mutate);
		int         len;
		int         i;
		int         pos;
		logic [7:0] b;
		text_buf.delete();
		len = (pat_len > 16) ? 16 : int'(pat_len);
		i = 0;
		while (i < len) begin
			b = pat_byte_at(i);
			if (i + 1 < len && pat_byte_at(i + 1) == dsp_pkg::STAR_BYTE) begin
				repeat ($urandom_range(3))
					text_buf.push_back(b == dsp_pkg::DOT_BYTE ? 8'($urandom) : b);
				i += 2;
			end else if (b == dsp_pkg::STAR_BYTE && i > 0) begin
				i++;
			end else begin
				text_buf.push_back(b == dsp_pkg::DOT_BYTE ? 8'($urandom) : b);
				i++;
			end
		end
		if (mutate) begin
			pos = $urandom_range(text_buf.size());
			case ($urandom_range(2))
				0: if (pos < text_buf.size()) text_buf[pos] = pick_text_byte();
				1: if (pos < text_buf.size()) text_buf.delete(pos);
				default: text_buf.insert(pos, pick_text_byte());
			endcase
		end
	endtask

	// Load a random pattern, then stream a few texts; the last may stay open.
	task automatic random_phase();
		logic [dsp_pkg::REG_W-1:0] lo;
		logic [dsp_pkg::REG_W-1:0] hi;
		logic [dsp_pkg::REG_W-1:0] len_word;
		int                        len;
		int                        r;
		int                        n_texts;
		for (int i = 0; i < 8; i++) begin
			lo[8*i +: 8] = pick_pattern_byte();
			hi[8*i +: 8] = pick_pattern_byte();
		end
		case ($urandom_range(19))
			0:       begin lo = '1; hi = '1; end
			1:       begin lo = '0; hi = '0; end
			default: ;
		endcase
		r = $urandom_range(99);
		if (r < 70)
			len = $urandom_range(8);
		else if (r < 85)
			len = $urandom_range(16, 9);
		else if (r < 92)
			len = 16;
		else
			len = $urandom_range(31, 17);
		len_word = dsp_pkg::REG_W'(len);
		// Junk above the length field must be ignored.
		if ($urandom_range(9) == 0)
			len_word = {$urandom, 27'($urandom), 5'(len)};
		wait_drained();
		write_reg(dsp_pkg::REG_CHARS_LOW, lo);
		write_reg(dsp_pkg::REG_CHARS_HIGH, hi);
		write_reg(dsp_pkg::REG_LENGTH, len_word);
		n_texts = $urandom_range(8, 2);
		for (int t = 0; t < n_texts; t++) begin
			r = $urandom_range(99);
			if (r < 65) begin
				sketch_matching_text(1'b0);
			end else if (r < 82) begin
				sketch_matching_text(1'b1);
			end else begin
				text_buf.delete();
				repeat ($urandom_range(10))
					text_buf.push_back(pick_text_byte());
			end
			send_text(t < n_texts - 1 || $urandom_range(6) != 0);
		end
	endtask

	// ---------------------------------------------------------------- receiver

	// Hold ready low during a requested stall, else idle at random.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= !(snk_gaps && $urandom_range(99) < 37);
		end
	end

	// Compare each result transfer against the oldest predicted verdict.
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (verdicts_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: matched=%0b text_done=%0b",
						out_ch.data.matched, out_ch.data.text_done);
			end else begin
				head_verdict = verdicts_due.pop_front();
				if (out_ch.data.matched !== head_verdict.matched ||
						out_ch.data.text_done !== head_verdict.text_done) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: expected matched=%0b text_done=%0b, got %0b %0b",
							results_seen, head_verdict.matched, head_verdict.text_done,
							out_ch.data.matched, out_ch.data.text_done);
				end
			end
			results_seen++;
		end
	end

	// ---------------------------------------------------------------- tests

	// Reset state: zero-length pattern accepts only the empty text.
	task automatic test_after_reset();
		feed_item(8'h00, 1'b0, 1'b1);
		feed_item(8'hFF, 1'b1, 1'b1);
		feed_item(8'h5A, 1'b0, 1'b0);
		feed_item(8'h00, 1'b1, 1'b1);
	endtask

	// Star at position 0 as literal, consecutive stars, dot-star with blank items.
	task automatic test_star_forms();
		set_pattern("*a.", 5'd3);
		feed_item("*", 1'b1, 1'b0);
		feed_item("a", 1'b1, 1'b0);
		feed_item("b", 1'b1, 1'b1);
		feed_item("*", 1'b1, 1'b0);
		feed_item("a", 1'b1, 1'b1);
		set_pattern("a**", 5'd3);
		feed_item("a", 1'b1, 1'b0);
		feed_item("*", 1'b1, 1'b0);
		feed_item("*", 1'b1, 1'b1);
		feed_item(8'h00, 1'b0, 1'b1);
		set_pattern(".*x", 5'd3);
		feed_item(8'h00, 1'b1, 1'b0);
		feed_item(8'hA5, 1'b0, 1'b0);
		feed_item(8'hFF, 1'b1, 1'b0);
		feed_item("x", 1'b1, 1'b1);
	endtask

	// Length above the row size clamps to the full row; upper word in use.
	task automatic test_oversized_length();
		set_pattern(".*.*.*.*.*.*.*.*", 5'd31);
		feed_item("q", 1'b1, 1'b1);
		feed_item(8'hFF, 1'b1, 1'b0);
		feed_item(dsp_pkg::STAR_BYTE, 1'b1, 1'b1);
	endtask

	// Shrink the length between bytes of an open text.
	task automatic test_pattern_change_mid_text();
		set_pattern("abc", 5'd3);
		feed_item("a", 1'b1, 1'b0);
		feed_item("b", 1'b1, 1'b0);
		wait_drained();
		write_reg(dsp_pkg::REG_LENGTH, dsp_pkg::REG_W'(2));
		feed_item(8'h00, 1'b0, 1'b1);
		set_pattern("abc", 5'd3);
		feed_item("a", 1'b1, 1'b0);
		feed_item("b", 1'b1, 1'b0);
		feed_item("c", 1'b1, 1'b0);
		wait_drained();
		write_reg(dsp_pkg::REG_LENGTH, dsp_pkg::REG_W'(2));
		feed_item(8'h00, 1'b0, 1'b1);
	endtask

	// Back-to-back transfers with both sides always ready.
	task automatic test_full_rate();
		src_gaps = 1'b0;
		snk_gaps = 1'b0;
		repeat (4) random_phase();
		src_gaps = 1'b1;
		snk_gaps = 1'b1;
	endtask

	// Stall the receiver long enough that the input stalls too, then drain.
	task automatic test_backpressure();
		set_pattern(".*a*b", 5'd5);
		src_gaps   = 1'b0;
		stall_left = 60;
		text_buf.delete();
		repeat (30) text_buf.push_back(pick_text_byte());
		send_text(1'b1);
		wait_drained();
		src_gaps = 1'b1;
	endtask

	task automatic test_random_texts(input int n_items);
		int stop_at;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			// Now and then run a phase with no idling on either side.
			src_gaps = ($urandom_range(99) >= 12);
			snk_gaps = src_gaps;
			random_phase();
		end
		src_gaps = 1'b1;
		snk_gaps = 1'b1;
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = dsp_pkg::REG_CHARS_LOW;
		cfg_data    = '0;
		in_ch.valid = 1'b0;
		in_ch.data  = '0;
		out_ch.ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_after_reset();
		test_star_forms();
		test_oversized_length();
		test_pattern_change_mid_text();
		test_full_rate();
		test_backpressure();
		test_random_texts(450);

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: sim.f
rtl/dsp_pkg.sv
rtl/dsp_if.sv
rtl/dsp_cell.sv
rtl/dot_star_pattern_matcher.sv
test/testbench.sv
